// ===== hw/rtl/tpa_pkg.sv =====
// tpa_pkg: widths, constants, register indexes and shared types of the
// timestamp PLL aligner. No dependencies.

package tpa_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned JITTER_W    = 32;
  localparam int unsigned PERIOD_W    = 32;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned INTEG_W     = 31;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  // phase error lies in [-2^40, 2^40]
  localparam int unsigned PHASE_W     = 42;
  localparam int unsigned DIFF_W      = STAMP_W + 2;
  localparam int unsigned PROD_W      = GAIN_W + 1 + PHASE_W;
  localparam int unsigned CORR_W      = PROD_W - FRAC_BITS;
  localparam int unsigned NEWINT_W    = PROD_W + 1;

  localparam logic signed [DIFF_W-1:0]   PHASE_HI = DIFF_W'(64'd1 << 40);
  localparam logic signed [DIFF_W-1:0]   PHASE_LO = -PHASE_HI;
  localparam logic signed [NEWINT_W-1:0] INTEG_HI = NEWINT_W'(64'd10000 << FRAC_BITS);
  localparam logic signed [NEWINT_W-1:0] INTEG_LO = -INTEG_HI;
  localparam logic signed [STAMP_W:0]    JIT_HI   = (STAMP_W+1)'(64'h7FFF_FFFF);
  localparam logic signed [STAMP_W:0]    JIT_LO   = -(STAMP_W+1)'(64'h8000_0000);

  localparam logic [PERIOD_W-1:0] RST_PERIOD    = PERIOD_W'(10000);
  localparam logic [GAIN_W-1:0]   RST_PHASE_G   = GAIN_W'(16384);
  localparam logic [GAIN_W-1:0]   RST_FREQ_G    = GAIN_W'(655);
  localparam logic [COUNT_W-1:0]  RST_LOCK_THR  = COUNT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOMINAL_PERIOD = 2'd0,
    CFG_PHASE_GAIN     = 2'd1,
    CFG_FREQ_GAIN      = 2'd2,
    CFG_LOCK_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] nominal_period_us;
    logic [GAIN_W-1:0]   phase_gain;
    logic [GAIN_W-1:0]   freq_gain;
    logic [COUNT_W-1:0]  lock_threshold;
  } cfg_t;

  typedef struct packed {
    logic [STAMP_W-1:0]         aligned_us;
    logic signed [JITTER_W-1:0] skew_us;
    logic                       anomaly;
    logic                       lock_state;
  } res_t;

endpackage

// ===== hw/rtl/tpa_ifs.sv =====
// tpa_ifs: valid/ready channel interfaces for sample and result beats.
// Depends on tpa_pkg.

interface tpa_in_if import tpa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] arrival_us;
  logic               gap_flag;

  modport source(output valid, arrival_us, gap_flag, input ready);
  modport sink(input valid, arrival_us, gap_flag, output ready);
endinterface

interface tpa_out_if import tpa_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [STAMP_W-1:0]         aligned_us;
  logic signed [JITTER_W-1:0] skew_us;
  logic                       anomaly;
  logic                       lock_state;

  modport source(output valid, aligned_us, skew_us, anomaly, lock_state, input ready);
  modport sink(input valid, aligned_us, skew_us, anomaly, lock_state, output ready);
endinterface

// ===== hw/rtl/tpa_loop.sv =====
// tpa_loop: loop state (last stamp, integrator, sample count, lock) and the
// combinational correction datapath. Depends on tpa_pkg.

module tpa_loop import tpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               step,
  input  logic [STAMP_W-1:0] arrival_us,
  input  logic               gap_flag,
  output res_t               res
);

  logic [STAMP_W-1:0]        prev_stamp;
  logic signed [INTEG_W-1:0] integrator;
  logic [COUNT_W-1:0]        sample_count;
  logic                      is_locked;

  logic [STAMP_W-1:0]        prev_stamp_next;
  logic signed [INTEG_W-1:0] integrator_next;
  logic [COUNT_W-1:0]        sample_count_next;
  logic                      is_locked_next;

  logic                       first;
  logic [STAMP_W:0]           est_sum;
  logic [STAMP_W-1:0]         est;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PHASE_W-1:0]  phi;
  logic signed [PROD_W-1:0]   prod_p;
  logic signed [PROD_W-1:0]   prod_f;
  logic signed [PROD_W-1:0]   corr_sum;
  logic signed [CORR_W-1:0]   corr;
  logic signed [DIFF_W-1:0]   cand;
  logic [STAMP_W-1:0]         stamp;
  logic                       loop_anom;
  logic signed [NEWINT_W-1:0] new_int;
  logic [COUNT_W-1:0]         count_inc;
  logic [STAMP_W-1:0]         aligned;
  logic signed [STAMP_W:0]    jd;
  logic signed [JITTER_W-1:0] jitter;

  always_comb begin
    first   = (sample_count == '0) && !is_locked;
    est_sum = {1'b0, prev_stamp} + (STAMP_W+1)'(cfg.nominal_period_us);
    est     = est_sum[STAMP_W] ? '1 : est_sum[STAMP_W-1:0];

    diff = $signed({2'b00, arrival_us}) - $signed({2'b00, est});
    if (diff > PHASE_HI) begin
      phi = PHASE_HI[PHASE_W-1:0];
    end else if (diff < PHASE_LO) begin
      phi = PHASE_LO[PHASE_W-1:0];
    end else begin
      phi = diff[PHASE_W-1:0];
    end

    prod_p   = $signed({1'b0, cfg.phase_gain}) * phi;
    prod_f   = $signed({1'b0, cfg.freq_gain}) * phi;
    corr_sum = prod_p + (is_locked ? PROD_W'(integrator) : PROD_W'(0));
    // arithmetic shift floors
    corr     = corr_sum[PROD_W-1:FRAC_BITS];
    cand     = $signed({2'b00, est}) + DIFF_W'(corr);

    loop_anom = 1'b0;
    if (cand[DIFF_W-1]) begin
      stamp     = est;
      loop_anom = 1'b1;
    end else if (cand[STAMP_W]) begin
      stamp     = '1;
      loop_anom = 1'b1;
    end else begin
      stamp = cand[STAMP_W-1:0];
    end
    if (stamp <= prev_stamp) begin
      stamp     = prev_stamp;
      loop_anom = 1'b1;
    end

    new_int = NEWINT_W'(integrator) + NEWINT_W'(prod_f);
    if (new_int > INTEG_HI) begin
      new_int = INTEG_HI;
    end else if (new_int < INTEG_LO) begin
      new_int = INTEG_LO;
    end

    count_inc = (sample_count == '1) ? sample_count : sample_count + COUNT_W'(1);

    prev_stamp_next   = prev_stamp;
    integrator_next   = integrator;
    sample_count_next = sample_count;
    is_locked_next    = is_locked;
    if (first) begin
      aligned           = arrival_us;
      res.anomaly       = 1'b0;
      prev_stamp_next   = arrival_us;
      sample_count_next = COUNT_W'(1);
    end else if (gap_flag) begin
      // est never falls below prev_stamp
      aligned         = est;
      res.anomaly     = 1'b1;
      prev_stamp_next = est;
    end else begin
      aligned           = stamp;
      res.anomaly       = loop_anom;
      prev_stamp_next   = stamp;
      sample_count_next = count_inc;
      if (is_locked) begin
        integrator_next = new_int[INTEG_W-1:0];
      end
      is_locked_next = is_locked || (count_inc >= cfg.lock_threshold);
    end

    jd = $signed({1'b0, arrival_us}) - $signed({1'b0, aligned});
    if (jd > JIT_HI) begin
      jitter = JIT_HI[JITTER_W-1:0];
    end else if (jd < JIT_LO) begin
      jitter = JIT_LO[JITTER_W-1:0];
    end else begin
      jitter = jd[JITTER_W-1:0];
    end

    res.aligned_us = aligned;
    res.skew_us    = jitter;
    res.lock_state = is_locked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_stamp   <= '0;
      integrator   <= '0;
      sample_count <= '0;
      is_locked    <= 1'b0;
    end else if (step) begin
      prev_stamp   <= prev_stamp_next;
      integrator   <= integrator_next;
      sample_count <= sample_count_next;
      is_locked    <= is_locked_next;
    end
  end

endmodule

// ===== hw/rtl/timestamp_pll_aligner.sv =====
// timestamp_pll_aligner: top level; configuration registers, sample input
// register and result register around tpa_loop. Depends on tpa_pkg, tpa_ifs, tpa_loop.
//
//   channel   dir   beat fields
//   sample    in    arrival_us[64], gap_flag
//   result    out   aligned_us[64], skew_us[32] signed, anomaly, lock_state
//   cfg_*     in    cfg_we, cfg_index[2], cfg_wdata[32]
//
// One sample per cycle while the result is not stalled; a sample goes through the
// input register, then the result register. Loop state feeds back combinationally,
// so the correction path (estimate add, phase multiply, candidate add) sets the
// clock period. Synchronous reset clears loop state and loads register defaults.
// A stalled result holds; the input register keeps taking beats while the
// result moves on in the same cycle.

module timestamp_pll_aligner import tpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  tpa_in_if.sink                sample,
  tpa_out_if.source             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t               cfg;
  logic               s1_valid;
  logic [STAMP_W-1:0] s1_arrival;
  logic               s1_gap;
  logic               res_valid;
  res_t               res_q;
  res_t               loop_res;
  logic               advance;
  logic               step;

  assign advance      = !res_valid || result.ready;
  assign step         = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_period_us <= RST_PERIOD;
      cfg.phase_gain        <= RST_PHASE_G;
      cfg.freq_gain         <= RST_FREQ_G;
      cfg.lock_threshold    <= RST_LOCK_THR;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NOMINAL_PERIOD: cfg.nominal_period_us <= cfg_wdata[PERIOD_W-1:0];
        CFG_PHASE_GAIN:     cfg.phase_gain        <= cfg_wdata[GAIN_W-1:0];
        CFG_FREQ_GAIN:      cfg.freq_gain         <= cfg_wdata[GAIN_W-1:0];
        CFG_LOCK_THRESHOLD: cfg.lock_threshold    <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (sample.ready) begin
        s1_valid <= sample.valid;
      end
      if (advance) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_arrival <= sample.arrival_us;
      s1_gap     <= sample.gap_flag;
    end
    if (step) begin
      res_q <= loop_res;
    end
  end

  tpa_loop u_loop (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (step),
    .arrival_us (s1_arrival),
    .gap_flag   (s1_gap),
    .res        (loop_res)
  );

  assign result.valid      = res_valid;
  assign result.aligned_us = res_q.aligned_us;
  assign result.skew_us    = res_q.skew_us;
  assign result.anomaly    = res_q.anomaly;
  assign result.lock_state = res_q.lock_state;

endmodule

// ===== hw/rtl/tpa_checker.sv =====
// tpa_checker: port-level assertions on the result stream of the aligner,
// bound to timestamp_pll_aligner. Depends on tpa_pkg.

module tpa_checker import tpa_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [STAMP_W-1:0]         aligned_us,
  input logic signed [JITTER_W-1:0] skew_us,
  input logic                       anomaly,
  input logic                       lock_state
);

  logic               out_fire;
  logic               have_last;
  logic [STAMP_W-1:0] last_aligned;
  logic               lock_seen;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
      lock_seen <= 1'b0;
    end else if (out_fire) begin
      have_last <= 1'b1;
      lock_seen <= lock_seen || lock_state;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      last_aligned <= aligned_us;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(aligned_us) && $stable(skew_us))
    else $error("stalled result beat changed");

  a_monotonic: assert property (@(posedge clk) disable iff (rst)
    out_fire && have_last |-> aligned_us >= last_aligned)
    else $error("aligned timestamp went backward");

  a_repeat_flagged: assert property (@(posedge clk) disable iff (rst)
    out_fire && have_last && aligned_us == last_aligned |-> anomaly)
    else $error("repeated timestamp without anomaly");

  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    out_fire && lock_seen |-> lock_state)
    else $error("lock dropped");

  a_anchor: assert property (@(posedge clk) disable iff (rst)
    out_fire && !have_last |-> skew_us == '0 && !anomaly && !lock_state)
    else $error("first result after reset not anchored");

endmodule

bind timestamp_pll_aligner tpa_checker u_tpa_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .aligned_us (result.aligned_us),
  .skew_us    (result.skew_us),
  .anomaly    (result.anomaly),
  .lock_state (result.lock_state)
);
